[rtl/core/etuc_pkg.sv]
// ----------------------------------------------------------------------------
// etuc_pkg
// Shared types, constants and tables for the epoch to UTC calendar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package etuc_pkg;

	// Field widths
	localparam int EPOCH_W  = 32;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int DAYS_W   = 16;   // day count since epoch, at most 49710
	localparam int C100_W   = 7;
	localparam int C400_W   = 9;
	localparam int MIDX_W   = 4;    // month index 0..11

	// Calendar constants
	localparam logic [YEAR_W-1:0]  EPOCH_YEAR     = 12'd1970;
	localparam logic [C100_W-1:0]  EPOCH_MOD100   = 7'd70;
	localparam logic [C400_W-1:0]  EPOCH_MOD400   = 9'd370;
	localparam logic [C100_W-1:0]  CENTURY_LAST   = 7'd99;
	localparam logic [C400_W-1:0]  QUADCENT_LAST  = 9'd399;
	localparam logic [DAYS_W-1:0]  YEAR_LEN_LEAP  = 16'd366;
	localparam logic [DAYS_W-1:0]  YEAR_LEN_PLAIN = 16'd365;
	localparam logic [MIDX_W-1:0]  MIDX_FEB       = 4'd1;
	localparam logic [MIDX_W-1:0]  MIDX_DEC       = 4'd11;
	localparam logic [DAY_W-1:0]   FEB_LEAP_LEN   = 5'd29;

	// Divide by constant through reciprocal multiply (exact for 32-bit operands)
	localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;   // 2^37 / 60, rounded up
	localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;   // 2^36 / 24, rounded up
	localparam logic [SEC_W-1:0]   DIV_60   = 6'd60;
	localparam logic [SEC_W-1:0]   DIV_24   = 6'd24;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	// Which time-of-day field a division step produces
	typedef enum logic [1:0] {
		DSEL_SEC,
		DSEL_MIN,
		DSEL_HOUR
	} dsel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  load;
		logic  mul;
		logic  div;
		dsel_t dsel;
		logic  year_step;
		logic  month_step;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic year_fit;     // remaining days fit inside the current year
		logic month_last;   // month walk ends on this step
	} status_t;

	// Days in a month, February without the leap day
	function automatic logic [DAY_W-1:0] month_len(input logic [MIDX_W-1:0] midx);
		logic [DAY_W-1:0] len;
		unique case (midx)
			4'd1:                     len = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[rtl/core/etuc_datapath.sv]
// ----------------------------------------------------------------------------
// etuc_datapath
// Shared reciprocal multiplier for the time of day, then a year walk and a
// month walk over the remaining day count, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module etuc_datapath (
	input  wire logic                              clk,
	input  wire etuc_pkg::cmd_t                    cmd,
	output etuc_pkg::status_t                      status,
	input  wire logic [etuc_pkg::EPOCH_W-1:0]      epoch_seconds,
	output logic      [etuc_pkg::YEAR_W-1:0]       year,
	output logic      [etuc_pkg::MONTH_W-1:0]      month,
	output logic      [etuc_pkg::DAY_W-1:0]        day,
	output logic      [etuc_pkg::HOUR_W-1:0]       hour,
	output logic      [etuc_pkg::MIN_W-1:0]        minute,
	output logic      [etuc_pkg::SEC_W-1:0]        second
);

	logic [etuc_pkg::EPOCH_W-1:0]   val_q;
	logic [2*etuc_pkg::EPOCH_W-1:0] prod_q;
	logic [etuc_pkg::DAYS_W-1:0]    days_q;
	logic [etuc_pkg::YEAR_W-1:0]    year_q;
	logic [etuc_pkg::C100_W-1:0]    c100_q;
	logic [etuc_pkg::C400_W-1:0]    c400_q;
	logic [etuc_pkg::MIDX_W-1:0]    midx_q;
	logic [etuc_pkg::SEC_W-1:0]     sec_q;
	logic [etuc_pkg::MIN_W-1:0]     min_q;
	logic [etuc_pkg::HOUR_W-1:0]    hour_q;

	logic [etuc_pkg::EPOCH_W-1:0]   recip;
	logic [etuc_pkg::SEC_W-1:0]     divisor;
	logic [etuc_pkg::EPOCH_W-1:0]   quot;
	logic [etuc_pkg::SEC_W-1:0]     rem;
	logic                           leap;
	logic [etuc_pkg::DAYS_W-1:0]    ylen;
	logic [etuc_pkg::DAY_W-1:0]     mlen;
	logic [etuc_pkg::DAYS_W-1:0]    mlen_w;

	// Divisor select
	always_comb begin
		if (cmd.dsel == etuc_pkg::DSEL_HOUR) begin
			recip   = etuc_pkg::RECIP_24;
			divisor = etuc_pkg::DIV_24;
			quot    = etuc_pkg::EPOCH_W'(prod_q[2*etuc_pkg::EPOCH_W-1:36]);
		end else begin
			recip   = etuc_pkg::RECIP_60;
			divisor = etuc_pkg::DIV_60;
			quot    = etuc_pkg::EPOCH_W'(prod_q[2*etuc_pkg::EPOCH_W-1:37]);
		end
	end

	// Remainder lives in the low six bits, so work modulo 64
	assign rem = etuc_pkg::SEC_W'(val_q[etuc_pkg::SEC_W-1:0]
		- etuc_pkg::SEC_W'(quot[etuc_pkg::SEC_W-1:0] * divisor));

	// Leap year from the running year residues
	assign leap = (year_q[1:0] == 2'd0) && ((c100_q != '0) || (c400_q == '0));
	assign ylen = leap ? etuc_pkg::YEAR_LEN_LEAP : etuc_pkg::YEAR_LEN_PLAIN;

	always_comb begin
		mlen = etuc_pkg::month_len(midx_q);
		if (leap && (midx_q == etuc_pkg::MIDX_FEB)) begin
			mlen = etuc_pkg::FEB_LEAP_LEN;
		end
	end
	assign mlen_w = etuc_pkg::DAYS_W'(mlen);

	assign status.year_fit   = (days_q < ylen);
	assign status.month_last = (days_q < mlen_w) || (midx_q == etuc_pkg::MIDX_DEC);

	// Multiply stage
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= val_q * recip;
		end
	end

	// Division result, time of day fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= epoch_seconds;
		end else if (cmd.div) begin
			val_q <= quot;
			case (cmd.dsel)
				etuc_pkg::DSEL_SEC:  sec_q  <= rem;
				etuc_pkg::DSEL_MIN:  min_q  <= rem;
				default:             hour_q <= etuc_pkg::HOUR_W'(rem);
			endcase
		end
	end

	// Year and month walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= etuc_pkg::EPOCH_YEAR;
			c100_q <= etuc_pkg::EPOCH_MOD100;
			c400_q <= etuc_pkg::EPOCH_MOD400;
			midx_q <= '0;
		end else if (cmd.div && (cmd.dsel == etuc_pkg::DSEL_HOUR)) begin
			days_q <= etuc_pkg::DAYS_W'(quot);
		end else if (cmd.year_step && !status.year_fit) begin
			days_q <= days_q - ylen;
			year_q <= year_q + 1'b1;
			c100_q <= (c100_q == etuc_pkg::CENTURY_LAST)  ? '0 : c100_q + 1'b1;
			c400_q <= (c400_q == etuc_pkg::QUADCENT_LAST) ? '0 : c400_q + 1'b1;
		end else if (cmd.month_step && (days_q >= mlen_w)) begin
			// Past December the month stays at December; the last step ends the walk
			days_q <= days_q - mlen_w;
			if (midx_q != etuc_pkg::MIDX_DEC) begin
				midx_q <= midx_q + 1'b1;
			end
		end
	end

	assign year   = year_q;
	assign month  = midx_q + 1'b1;
	assign day    = days_q[etuc_pkg::DAY_W-1:0] + 1'b1;
	assign hour   = hour_q;
	assign minute = min_q;
	assign second = sec_q;

endmodule

`default_nettype wire

[rtl/core/etuc_ctrl.sv]
// ----------------------------------------------------------------------------
// etuc_ctrl
// Sequencer: three multiply/divide passes, year walk, month walk, result.
// ----------------------------------------------------------------------------
`default_nettype none

module etuc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	output logic                     done,
	output etuc_pkg::cmd_t           cmd,
	input  wire etuc_pkg::status_t   status
);

	etuc_pkg::state_t state_q, state_d;
	etuc_pkg::dsel_t  dsel_q, dsel_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= etuc_pkg::ST_IDLE;
			dsel_q  <= etuc_pkg::DSEL_SEC;
		end else begin
			state_q <= state_d;
			dsel_q  <= dsel_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		dsel_d  = dsel_q;
		cmd     = '0;
		cmd.dsel = dsel_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			etuc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					dsel_d   = etuc_pkg::DSEL_SEC;
					state_d  = etuc_pkg::ST_MUL;
				end
			end
			etuc_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = etuc_pkg::ST_DIV;
			end
			etuc_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				unique case (dsel_q)
					etuc_pkg::DSEL_SEC: begin
						dsel_d  = etuc_pkg::DSEL_MIN;
						state_d = etuc_pkg::ST_MUL;
					end
					etuc_pkg::DSEL_MIN: begin
						dsel_d  = etuc_pkg::DSEL_HOUR;
						state_d = etuc_pkg::ST_MUL;
					end
					default: begin
						dsel_d  = etuc_pkg::DSEL_SEC;
						state_d = etuc_pkg::ST_YEAR;
					end
				endcase
			end
			etuc_pkg::ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (status.year_fit) begin
					state_d = etuc_pkg::ST_MONTH;
				end
			end
			etuc_pkg::ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (status.month_last) begin
					state_d = etuc_pkg::ST_DONE;
				end
			end
			etuc_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = etuc_pkg::ST_IDLE;
			end
			default: begin
				state_d = etuc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/epoch_to_utc_calendar_unit.sv]
// ----------------------------------------------------------------------------
// epoch_to_utc_calendar_unit
// Converts a 32-bit Unix time to UTC year, month, day, hour, minute, second.
// ----------------------------------------------------------------------------
// A transaction is accepted on a clock edge with start high and busy low. The
// result appears for exactly one cycle with done high and must be captured
// then; it cannot be held off. From the accepting edge a conversion makes three
// passes through the shared reciprocal multiplier (seconds, minutes, hours),
// each a multiply state and a divide state, then a year step for each whole
// year past 1970 (0 to 136) and a month step for each month index (0 to 11),
// then the done cycle;
// busy falls after done and the next transaction may start on the following
// edge. The field ports keep their values until the next conversion runs.
`default_nettype none

module epoch_to_utc_calendar_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [etuc_pkg::EPOCH_W-1:0]      epoch_seconds,
	output logic                                   done,
	output logic      [etuc_pkg::YEAR_W-1:0]       year,
	output logic      [etuc_pkg::MONTH_W-1:0]      month,
	output logic      [etuc_pkg::DAY_W-1:0]        day,
	output logic      [etuc_pkg::HOUR_W-1:0]       hour,
	output logic      [etuc_pkg::MIN_W-1:0]        minute,
	output logic      [etuc_pkg::SEC_W-1:0]        second
);

	etuc_pkg::cmd_t    cmd;
	etuc_pkg::status_t status;

	// Sequencer
	etuc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// Arithmetic and result registers
	etuc_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.epoch_seconds (epoch_seconds),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

endmodule

`default_nettype wire

[test/epoch_to_utc_calendar_checker.sv]
// ----------------------------------------------------------------------------
// epoch_to_utc_calendar_checker
// Scoreboard for the epoch to UTC calendar unit: watches start/busy and done,
// predicts the civil date for every accepted timestamp and compares results.
// ----------------------------------------------------------------------------
module epoch_to_utc_calendar_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [etuc_pkg::EPOCH_W-1:0]      epoch_seconds,
	input  logic                              done,
	input  logic [etuc_pkg::YEAR_W-1:0]       year,
	input  logic [etuc_pkg::MONTH_W-1:0]      month,
	input  logic [etuc_pkg::DAY_W-1:0]        day,
	input  logic [etuc_pkg::HOUR_W-1:0]       hour,
	input  logic [etuc_pkg::MIN_W-1:0]        minute,
	input  logic [etuc_pkg::SEC_W-1:0]        second,
	output int                                failures,
	output int                                outstanding,
	output int                                checked,
	output int                                leap_days,
	output int                                first_year,
	output int                                last_year
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [etuc_pkg::YEAR_W-1:0]  year;
		logic [etuc_pkg::MONTH_W-1:0] month;
		logic [etuc_pkg::DAY_W-1:0]   day;
		logic [etuc_pkg::HOUR_W-1:0]  hour;
		logic [etuc_pkg::MIN_W-1:0]   minute;
		logic [etuc_pkg::SEC_W-1:0]   second;
	} civil_time_t;

	localparam int unsigned DAYS_PER_MONTH [12] =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int REPORT_LIMIT = 10;

	civil_time_t pending_dates[$];

	function automatic bit is_leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// Civil date and time for a Unix timestamp: divide out the time of day,
	// then walk whole years from 1970 and month lengths within the year.
	function automatic civil_time_t civil_from_epoch(
		input logic [etuc_pkg::EPOCH_W-1:0] secs
	);
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		bit          leap;
		civil_time_t c;
		t        = secs;
		c.second = etuc_pkg::SEC_W'(t % 60);
		t        = t / 60;
		c.minute = etuc_pkg::MIN_W'(t % 60);
		t        = t / 60;
		c.hour   = etuc_pkg::HOUR_W'(t % 24);
		days     = t / 24;
		yr       = 32'(etuc_pkg::EPOCH_YEAR);
		while (days >= (is_leap_year(yr) ? 366 : 365)) begin
			days -= is_leap_year(yr) ? 366 : 365;
			yr++;
		end
		leap = is_leap_year(yr);
		mon  = 0;
		while (mon < 12) begin
			mlen = (mon == 1 && leap) ? 29 : DAYS_PER_MONTH[mon];
			if (days < mlen)
				break;
			days -= mlen;
			mon++;
		end
		// walk past December cannot happen; clamp as the calendar would
		if (mon > 11)
			mon = 11;
		c.year  = etuc_pkg::YEAR_W'(yr);
		c.month = etuc_pkg::MONTH_W'(mon + 1);
		c.day   = etuc_pkg::DAY_W'(days + 1);
		return c;
	endfunction

	// Results are compared first so a done and a new transaction on the same
	// edge stay in order.
	always @(posedge clk or negedge arst_n) begin
		civil_time_t want;
		civil_time_t got;
		if (!arst_n) begin
			failures    <= 0;
			outstanding <= 0;
			checked     <= 0;
			leap_days   <= 0;
			first_year  <= 9999;
			last_year   <= 0;
		end else begin
			if (done) begin
				got = '{year, month, day, hour, minute, second};
				if (pending_dates.size() == 0) begin
					if (failures < REPORT_LIMIT)
						$display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d",
							$realtime, year, month, day, hour, minute, second);
					failures <= failures + 1;
				end else begin
					want = pending_dates.pop_front();
					checked <= checked + 1;
					if (want.month == 2 && want.day == 29)
						leap_days <= leap_days + 1;
					if (int'(want.year) < first_year)
						first_year <= int'(want.year);
					if (int'(want.year) > last_year)
						last_year <= int'(want.year);
					if (got !== want) begin
						if (failures < REPORT_LIMIT)
							$display("[%0t] mismatch: expected %0d-%0d-%0d %0d:%0d:%0d,",
								$realtime,
								want.year, want.month, want.day,
								want.hour, want.minute, want.second,
								" got %0d-%0d-%0d %0d:%0d:%0d",
								got.year, got.month, got.day,
								got.hour, got.minute, got.second);
						failures <= failures + 1;
					end
				end
			end
			// new transaction accepted
			if (start && !busy)
				pending_dates.push_back(civil_from_epoch(epoch_seconds));
			outstanding <= pending_dates.size();
		end
	end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the epoch to UTC calendar unit: directed boundary timestamps,
// then bursts of random ones with random gaps, checked by a scoreboard.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1450;
	localparam int DRAIN_CYCLES = 200;
	localparam int LAST_DAY     = 49709;    // last whole day below 2^32 seconds

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [etuc_pkg::EPOCH_W-1:0]   epoch_seconds;
	logic                           done;
	logic [etuc_pkg::YEAR_W-1:0]    year;
	logic [etuc_pkg::MONTH_W-1:0]   month;
	logic [etuc_pkg::DAY_W-1:0]     day;
	logic [etuc_pkg::HOUR_W-1:0]    hour;
	logic [etuc_pkg::MIN_W-1:0]     minute;
	logic [etuc_pkg::SEC_W-1:0]     second;
	int                             failures;
	int                             outstanding;
	int                             checked;
	int                             leap_days;
	int                             first_year;
	int                             last_year;

	epoch_to_utc_calendar_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.epoch_seconds (epoch_seconds),
		.done          (done),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	epoch_to_utc_calendar_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.epoch_seconds (epoch_seconds),
		.done          (done),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.failures      (failures),
		.outstanding   (outstanding),
		.checked       (checked),
		.leap_days     (leap_days),
		.first_year    (first_year),
		.last_year     (last_year)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Present one timestamp and hold it until the unit takes it; start stays
	// high so a following call goes out back to back.
	task automatic convert_timestamp(input logic [etuc_pkg::EPOCH_W-1:0] t);
		@(negedge clk);
		start         <= 1'b1;
		epoch_seconds <= t;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Sender idle with start low and junk on the data port, for a span set by n
	task automatic hold_off(input int n);
		if (n > 0) begin
			@(negedge clk);
			start         <= 1'b0;
			epoch_seconds <= $urandom;
			repeat (n - 1) begin
				@(negedge clk);
				epoch_seconds <= $urandom;
			end
		end
	endtask

	// Pause until every outstanding conversion has come back
	task automatic wait_for_results();
		hold_off(1);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Half are a random whole day at its first second, its last second or a random
	// second; the rest uniform over the full 32-bit range or near the epoch.
	function automatic logic [etuc_pkg::EPOCH_W-1:0] random_timestamp();
		int unsigned      pick;
		int unsigned      days;
		int unsigned      offset;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom;
		if (pick == 9)
			return $urandom_range(0, 100000);
		days = $urandom_range(0, LAST_DAY);
		case ($urandom_range(0, 2))
			0:       offset = 0;
			1:       offset = 86399;
			default: offset = $urandom_range(0, 86399);
		endcase
		return etuc_pkg::EPOCH_W'(days * 86400 + offset);
	endfunction

	initial begin
		logic [etuc_pkg::EPOCH_W-1:0] corner_times [$];
		int                           sent;
		int                           burst;
		bit                           mid_drain_done;
		arst_n         = 1'b0;
		start          = 1'b0;
		epoch_seconds  = '0;
		mid_drain_done = 1'b0;
		sent           = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		hold_off(2);

		// Field extremes, rollovers of every unit, leap and century rules
		corner_times = '{
			32'd0,          32'hFFFF_FFFF,  32'd59,         32'd60,
			32'd3599,       32'd3600,       32'd86399,      32'd86400,
			32'd31535999,   32'd31536000,   32'd68169600,   32'd68255999,
			32'd68256000,   32'd946684799,  32'd951782400,  32'd978307199,
			32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
			32'hAAAA_AAAA,  32'h5555_5555
		};
		foreach (corner_times[i])
			convert_timestamp(corner_times[i]);
		wait_for_results();

		// Random bursts; some with no gap, some gaps long enough to go idle
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				convert_timestamp(random_timestamp());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 180));
			if (!mid_drain_done && sent >= RANDOM_ITEMS / 2) begin
				wait_for_results();
				mid_drain_done = 1'b1;
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d timestamps spanning years %0d to %0d, %0d on a leap day.",
			checked, first_year, last_year, leap_days);
		if (failures == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
